// File: src/sccr_pkg.sv
package sccr_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAG_RD,
        S_TAG_CMP,
        S_SWEEP_RD,
        S_SWEEP_CHK
    } state_t;

    typedef struct packed {
        logic accept;
        logic idx_inc;
        logic rd_hand;
        logic hit_commit;
        logic sweep_clear;
        logic miss_commit;
    } cmd_t;

    typedef struct packed {
        logic fill_empty;
        logic match;
        logic scan_last;
        logic ref_set;
        logic out_free;
    } status_t;

    localparam int SECTOR_W = 32;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 32;

endpackage

// File: src/sector_cache_clock_replace.sv
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_sector
// m_      | out       | m_valid / m_ready  | m_hit, m_slot, m_victim_was_valid,
//         |           |                    | m_victim_sector, m_hit_total, m_miss_total
//
// Tags live in a single-read-port memory and are scanned one entry at a time, each
// read in S_TAG_RD and compared in S_TAG_CMP, from slot 0 up to the last filled slot; a
// miss then sweeps from the hand, clearing set reference bits, to the victim slot.
// Reset clears hand, fill count, totals and output valid only; validity follows the fill count,
// so there is no clearing pass.
// A stalled result holds the next item at its final step; one item in flight.
module sector_cache_clock_replace
    import sccr_pkg::*;
#(
    parameter int NUM_SLOTS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SECTOR_W-1:0] s_sector,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic [SLOT_W-1:0]   m_slot,
    output logic                m_victim_was_valid,
    output logic [SECTOR_W-1:0] m_victim_sector,
    output logic [COUNT_W-1:0]  m_hit_total,
    output logic [COUNT_W-1:0]  m_miss_total
);

    cmd_t    cmd;
    status_t sts;

    sccr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sccr_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_sector           (s_sector),
        .cmd                (cmd),
        .sts                (sts),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_hit              (m_hit),
        .m_slot             (m_slot),
        .m_victim_was_valid (m_victim_was_valid),
        .m_victim_sector    (m_victim_sector),
        .m_hit_total        (m_hit_total),
        .m_miss_total       (m_miss_total)
    );

endmodule

// File: src/sccr_ctrl.sv
module sccr_ctrl
    import sccr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.fill_empty ? S_SWEEP_RD : S_TAG_RD;
                end
            end
            S_TAG_RD: begin
                state_next = S_TAG_CMP;
            end
            S_TAG_CMP: begin
                if (sts.match) begin
                    if (sts.out_free) begin
                        cmd.hit_commit = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else if (sts.scan_last) begin
                    state_next = S_SWEEP_RD;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_TAG_RD;
                end
            end
            S_SWEEP_RD: begin
                cmd.rd_hand = 1'b1;
                state_next  = S_SWEEP_CHK;
            end
            S_SWEEP_CHK: begin
                cmd.rd_hand = 1'b1;
                if (sts.ref_set) begin
                    cmd.sweep_clear = 1'b1;
                    state_next      = S_SWEEP_RD;
                end else if (sts.out_free) begin
                    cmd.miss_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/sccr_datapath.sv
module sccr_datapath
    import sccr_pkg::*;
#(
    parameter int NUM_SLOTS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [SECTOR_W-1:0] s_sector,
    input  cmd_t                cmd,
    output status_t             sts,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic [SLOT_W-1:0]   m_slot,
    output logic                m_victim_was_valid,
    output logic [SECTOR_W-1:0] m_victim_sector,
    output logic [COUNT_W-1:0]  m_hit_total,
    output logic [COUNT_W-1:0]  m_miss_total
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    logic [SECTOR_W-1:0] sector_mem [NUM_SLOTS];
    logic                ref_mem    [NUM_SLOTS];

    logic [SECTOR_W-1:0] req_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    hand_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [COUNT_W-1:0]  hits_reg;
    logic [COUNT_W-1:0]  misses_reg;
    logic [SECTOR_W-1:0] sector_q_reg;
    logic                ref_q_reg;

    logic                m_valid_reg;
    logic                m_hit_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic                m_vvalid_reg;
    logic [SECTOR_W-1:0] m_vsector_reg;
    logic [COUNT_W-1:0]  m_hit_total_reg;
    logic [COUNT_W-1:0]  m_miss_total_reg;

    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    ref_waddr;
    logic                ref_we;
    logic [IDX_W-1:0]    hand_next;
    logic                hand_valid;
    logic [COUNT_W-1:0]  hits_inc;
    logic [COUNT_W-1:0]  misses_inc;
    logic                out_free;

    assign rd_addr    = cmd.rd_hand ? hand_reg : idx_reg;
    assign ref_we     = cmd.hit_commit | cmd.sweep_clear | cmd.miss_commit;
    assign ref_waddr  = cmd.hit_commit ? idx_reg : hand_reg;
    assign hand_next  = (hand_reg == IDX_W'(NUM_SLOTS - 1)) ? '0 : hand_reg + 1'b1;
    assign hand_valid = CNT_W'(hand_reg) < fill_reg;
    assign hits_inc   = (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
    assign misses_inc = (misses_reg == '1) ? misses_reg : misses_reg + 1'b1;
    assign out_free   = !m_valid_reg || m_ready;

    assign sts.fill_empty = (fill_reg == '0);
    assign sts.match      = (sector_q_reg == req_reg);
    assign sts.scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);
    assign sts.ref_set    = ref_q_reg && hand_valid;
    assign sts.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.miss_commit) begin
            sector_mem[hand_reg] <= req_reg;
        end
        if (ref_we) begin
            ref_mem[ref_waddr] <= !cmd.sweep_clear;
        end
        sector_q_reg <= sector_mem[rd_addr];
        ref_q_reg    <= ref_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= s_sector;
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hand_reg    <= '0;
            fill_reg    <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.sweep_clear || cmd.miss_commit) begin
                hand_reg <= hand_next;
            end
            if (cmd.miss_commit && !hand_valid) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.hit_commit) begin
                hits_reg <= hits_inc;
            end
            if (cmd.miss_commit) begin
                misses_reg <= misses_inc;
            end
            if (cmd.hit_commit || cmd.miss_commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hit_commit) begin
            m_hit_reg        <= 1'b1;
            m_slot_reg       <= SLOT_W'(idx_reg);
            m_vvalid_reg     <= 1'b0;
            m_vsector_reg    <= '0;
            m_hit_total_reg  <= hits_inc;
            m_miss_total_reg <= misses_reg;
        end else if (cmd.miss_commit) begin
            m_hit_reg        <= 1'b0;
            m_slot_reg       <= SLOT_W'(hand_reg);
            m_vvalid_reg     <= hand_valid;
            m_vsector_reg    <= hand_valid ? sector_q_reg : '0;
            m_hit_total_reg  <= hits_reg;
            m_miss_total_reg <= misses_inc;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_hit              = m_hit_reg;
    assign m_slot             = m_slot_reg;
    assign m_victim_was_valid = m_vvalid_reg;
    assign m_victim_sector    = m_vsector_reg;
    assign m_hit_total        = m_hit_total_reg;
    assign m_miss_total       = m_miss_total_reg;

`ifndef SYNTHESIS
    // until the cache fills, the hand points at the next empty slot
    a_hand_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != CNT_W'(NUM_SLOTS)) |-> (CNT_W'(hand_reg) == fill_reg))
        else $error("hand out of step with fill count");

    a_commit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.hit_commit || cmd.miss_commit) |-> out_free)
        else $error("result overwrites pending transfer");

    a_hit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hit_commit |=> (m_valid_reg && m_hit_reg && !m_vvalid_reg))
        else $error("hit result not presented");

    a_miss_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.miss_commit |=> (m_valid_reg && !m_hit_reg))
        else $error("miss result not presented");
`endif

endmodule
